FILE: sv/nfd_pkg.sv
// ----------------------------------------------------------------------------
// Navigation frame deframer package
// Byte codes, field layout and widths shared by the deframer and its checker.
// ----------------------------------------------------------------------------
package nfd_pkg;

  // Frame markers
  localparam logic [7:0] HDR_BYTE = 8'hBD;
  localparam logic [7:0] ID_BYTE  = 8'h0B;

  // Held frame bytes: only offsets 3 to 39 carry field data
  localparam int HELD_LO = 3;
  localparam int HELD_HI = 39;

  // Field layout
  localparam int NUM_FIELDS = 16;
  localparam int FIELD_ID_W = 4;
  localparam int FIELD_VAL_W = 32;
  localparam logic [FIELD_ID_W-1:0] LAST_FIELD_ID = 4'd15;

  localparam logic [5:0] FLD_OFFSET [NUM_FIELDS] = '{
    6'd3, 6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd17,
    6'd19, 6'd21, 6'd25, 6'd29, 6'd33, 6'd35, 6'd37, 6'd39
  };
  localparam logic [2:0] FLD_SIZE [NUM_FIELDS] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd1
  };

  typedef logic [7:0]             byte_t;
  typedef logic [FIELD_ID_W-1:0]  field_id_t;
  typedef logic [FIELD_VAL_W-1:0] field_val_t;

endpackage

FILE: sv/nav_frame_deframer_top.sv
// Output: the fields of a good frame appear in the cycle after its checksum byte
// is accepted, one field per cycle while the field channel does not stall.
// Input: one byte per cycle; a checksum byte is stalled only while the
// previous frame's run is still being delivered.
// Reset: the deframer returns to hunting for a header and no run is pending.
// ----------------------------------------------------------------------------
// Navigation frame deframer
// Finds header and identifier bytes, checks the XOR checksum and delivers the
// sixteen raw fields of each good frame as a run of output transactions.
// ----------------------------------------------------------------------------
module nav_frame_deframer_top #(
  parameter int FRAME_LENGTH = 58
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rx_valid_i,
  output logic                           rx_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           fld_valid_o,
  input  logic                           fld_stall_i,
  output logic [nfd_pkg::FIELD_ID_W-1:0] field_id_o,
  output logic signed [nfd_pkg::FIELD_VAL_W-1:0] field_value_o,
  output logic                           last_o
);

  localparam int PosW = $clog2(FRAME_LENGTH);
  localparam logic [PosW-1:0] CsumPos = PosW'(FRAME_LENGTH - 1);

  // Deframer state
  logic [PosW-1:0]     pos_q, pos_d;
  nfd_pkg::byte_t      xor_q, xor_d;
  logic                early_hdr_q, early_hdr_d;
  nfd_pkg::byte_t      held_q [nfd_pkg::HELD_LO:nfd_pkg::HELD_HI];
  nfd_pkg::byte_t      snap_q [nfd_pkg::HELD_LO:nfd_pkg::HELD_HI];

  // Output run state
  logic                busy_q, busy_d;
  nfd_pkg::field_id_t  cnt_q, cnt_d;

  logic rx_acc, fld_acc, is_csum, body_byte, good_frame;
  logic is_hdr, is_id;
  nfd_pkg::field_val_t fval [nfd_pkg::NUM_FIELDS];

  assign is_csum    = (pos_q >= CsumPos);
  assign rx_stall_o = busy_q && is_csum;
  assign rx_acc     = rx_valid_i && !rx_stall_o;
  assign fld_acc    = fld_valid_o && !fld_stall_i;
  assign is_hdr     = (rx_byte_i == nfd_pkg::HDR_BYTE);
  assign is_id      = (rx_byte_i == nfd_pkg::ID_BYTE);
  assign body_byte  = rx_acc && (pos_q > PosW'(2)) && !is_csum;
  assign good_frame = rx_acc && is_csum && (rx_byte_i == xor_q);

  // Frame tracking: header hunt, identifier check with resync, checksum
  always_comb begin
    pos_d       = pos_q;
    xor_d       = xor_q;
    early_hdr_d = early_hdr_q;
    if (rx_acc) begin
      if (pos_q == '0) begin
        if (is_hdr) begin
          pos_d       = PosW'(1);
          xor_d       = nfd_pkg::HDR_BYTE;
          early_hdr_d = 1'b0;
        end
      end else if (pos_q == PosW'(1)) begin
        pos_d       = PosW'(2);
        xor_d       = xor_q ^ rx_byte_i;
        early_hdr_d = is_hdr;
      end else if (pos_q == PosW'(2)) begin
        if (is_id) begin
          pos_d = PosW'(3);
          xor_d = xor_q ^ rx_byte_i;
        end else if (early_hdr_q) begin
          // Byte 1 was a header: restart there with two bytes seen.
          pos_d       = PosW'(2);
          xor_d       = nfd_pkg::HDR_BYTE ^ rx_byte_i;
          early_hdr_d = is_hdr;
        end else if (is_hdr) begin
          // This byte is a header: restart with one byte seen.
          pos_d       = PosW'(1);
          xor_d       = nfd_pkg::HDR_BYTE;
          early_hdr_d = 1'b0;
        end else begin
          pos_d       = '0;
          xor_d       = '0;
          early_hdr_d = 1'b0;
        end
      end else if (!is_csum) begin
        pos_d = pos_q + PosW'(1);
        xor_d = xor_q ^ rx_byte_i;
      end else begin
        pos_d       = '0;
        xor_d       = '0;
        early_hdr_d = 1'b0;
      end
    end
  end

  // Run counter: a good frame starts a run, each accepted field advances it
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (good_frame) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (fld_acc) begin
      cnt_d = cnt_q + nfd_pkg::FIELD_ID_W'(1);
      if (cnt_q == nfd_pkg::LAST_FIELD_ID) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      xor_q       <= '0;
      early_hdr_q <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      pos_q       <= pos_d;
      xor_q       <= xor_d;
      early_hdr_q <= early_hdr_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
    end
  end

  // Byte store and snapshot: each entry is written at its own frame offset
  for (genvar e = nfd_pkg::HELD_LO; e <= nfd_pkg::HELD_HI; e++) begin : g_held
    always_ff @(posedge clk_i) begin
      if (body_byte && (pos_q == PosW'(e))) begin
        held_q[e] <= rx_byte_i;
      end
      if (good_frame) begin
        snap_q[e] <= held_q[e];
      end
    end
  end

  // Field assembly from fixed snapshot positions, little-endian
  for (genvar k = 0; k < nfd_pkg::NUM_FIELDS; k++) begin : g_fld
    localparam int Off = int'(nfd_pkg::FLD_OFFSET[k]);
    if (nfd_pkg::FLD_SIZE[k] == 3'd4) begin : g_w32
      assign fval[k] = {snap_q[Off+3], snap_q[Off+2], snap_q[Off+1], snap_q[Off]};
    end else if (nfd_pkg::FLD_SIZE[k] == 3'd2) begin : g_w16
      assign fval[k] = {{16{snap_q[Off+1][7]}}, snap_q[Off+1], snap_q[Off]};
    end else begin : g_w8
      assign fval[k] = {24'd0, snap_q[Off]};
    end
  end

  // Output transaction
  assign fld_valid_o   = busy_q;
  assign field_id_o    = cnt_q;
  assign field_value_o = fval[cnt_q];
  assign last_o        = (cnt_q == nfd_pkg::LAST_FIELD_ID);

endmodule

FILE: sv/nfd_checker.sv
// ----------------------------------------------------------------------------
// Navigation frame deframer checker
// Port-level checks on the ordering of field runs and on input stalling.
// ----------------------------------------------------------------------------
module nfd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           rx_stall_i,
  input logic                           fld_valid_i,
  input logic                           fld_stall_i,
  input logic [nfd_pkg::FIELD_ID_W-1:0] field_id_i,
  input logic                           last_i
);

  // The last flag is carried only by the final field of a run.
  a_last_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_valid_i && last_i |-> field_id_i == nfd_pkg::LAST_FIELD_ID)
    else $error("last flag on a field other than the final one");

  // A run always opens with the first field.
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fld_valid_i) |-> field_id_i == '0)
    else $error("field run did not start at field zero");

  // Fields of a run follow one another without gaps.
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_valid_i && !fld_stall_i && !last_i |=>
      fld_valid_i && field_id_i == $past(field_id_i) + nfd_pkg::FIELD_ID_W'(1))
    else $error("field run broken or out of order");

  // The input is held back only while a run is being delivered.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_i |-> fld_valid_i)
    else $error("input stalled with no field run pending");

endmodule

bind nav_frame_deframer_top nfd_checker u_nfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_stall_i  (rx_stall_o),
  .fld_valid_i (fld_valid_o),
  .fld_stall_i (fld_stall_i),
  .field_id_i  (field_id_o),
  .last_i      (last_o)
);
